FILE: src/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types, register indexes and pipeline latencies of the environmental
// sensor compensation block.
// ----------------------------------------------------------------------------
package esc_pkg;

  localparam int unsigned CfgIdxW         = 3;
  localparam int unsigned CfgDataW        = 64;
  localparam int unsigned TempLat         = 3;
  localparam int unsigned HumLat          = 7;
  localparam int unsigned DivBits         = 64;
  localparam int unsigned DivBitsPerStage = 2;
  localparam int unsigned DivStages       = DivBits / DivBitsPerStage;
  localparam int unsigned PressPreLat     = 5;
  localparam int unsigned PressPostLat    = 3;
  localparam int unsigned PressLat        = PressPreLat + DivStages + 1 + PressPostLat;
  localparam int unsigned TotalLat        = TempLat + PressLat;

  localparam logic signed [31:0] HumClampMax = 32'sd419430400;

  typedef enum logic [CfgIdxW-1:0] {
    CfgCalTemp     = 3'd0,
    CfgCalPressLo  = 3'd1,
    CfgCalPressHi  = 3'd2,
    CfgCalPressNine = 3'd3,
    CfgCalHumA     = 3'd4,
    CfgCalHumB     = 3'd5,
    CfgHasHumidity = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic        [15:0] t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic        [15:0] p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
    logic        [7:0]  h1;
    logic signed [15:0] h2;
    logic        [7:0]  h3;
    logic signed [15:0] h4;
    logic signed [15:0] h5;
    logic signed [7:0]  h6;
    logic               has_hum;
  } cal_t;

endpackage

FILE: src/environmental_sensor_compensation_top.sv
// ----------------------------------------------------------------------------
// environmental_sensor_compensation_top
// Integer temperature, pressure and humidity compensation from raw readings.
// ----------------------------------------------------------------------------
// One reading transfer is taken in every clock cycle (busy_o stays low). The
// results of a reading appear on done_o for one cycle, in order; the receiver
// cannot stall them. The depth is set by the temperature pipeline and then the
// pressure path: five stages before the division, a 32-stage divider retiring
// two quotient bits per stage, a sign stage and three stages after.
// Calibration registers are written through cfg_we_i; the user must do so only
// while no reading is in flight, as the block itself does not enforce it.
module environmental_sensor_compensation_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [19:0]                       raw_temp_i,
  input  logic [19:0]                       raw_press_i,
  input  logic [15:0]                       raw_hum_i,
  input  logic                              cfg_we_i,
  input  logic [esc_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [esc_pkg::CfgDataW-1:0]      cfg_wdata_i,
  output logic                              done_o,
  output logic signed [31:0]                temp_centi_o,
  output logic [31:0]                       press_q24_8_o,
  output logic [16:0]                       hum_q22_10_o
);
  import esc_pkg::*;

  logic [47:0] cal_temp_q;
  logic [63:0] cal_press_lo_q, cal_press_hi_q;
  logic [15:0] cal_press_nine_q;
  logic [39:0] cal_hum_a_q;
  logic [31:0] cal_hum_b_q;
  logic        has_hum_q;
  cal_t        cal;

  logic               accept;
  logic [TotalLat-1:0] vld_q;
  logic [19:0]        rp_q [TempLat];
  logic [15:0]        rh_q [TempLat];
  logic signed [31:0] fine, temp;
  logic [16:0]        hum;
  logic [31:0]        press;
  logic signed [31:0] temp_dly_q [PressLat];
  logic [16:0]        hum_dly_q [PressLat-HumLat];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_temp_q       <= '0;
      cal_press_lo_q   <= '0;
      cal_press_hi_q   <= '0;
      cal_press_nine_q <= '0;
      cal_hum_a_q      <= '0;
      cal_hum_b_q      <= '0;
      has_hum_q        <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgCalTemp:      cal_temp_q       <= cfg_wdata_i[47:0];
        CfgCalPressLo:   cal_press_lo_q   <= cfg_wdata_i;
        CfgCalPressHi:   cal_press_hi_q   <= cfg_wdata_i;
        CfgCalPressNine: cal_press_nine_q <= cfg_wdata_i[15:0];
        CfgCalHumA:      cal_hum_a_q      <= cfg_wdata_i[39:0];
        CfgCalHumB:      cal_hum_b_q      <= cfg_wdata_i[31:0];
        CfgHasHumidity:  has_hum_q        <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cal.t1      = cal_temp_q[15:0];
    cal.t2      = cal_temp_q[31:16];
    cal.t3      = cal_temp_q[47:32];
    cal.p1      = cal_press_lo_q[15:0];
    cal.p2      = cal_press_lo_q[31:16];
    cal.p3      = cal_press_lo_q[47:32];
    cal.p4      = cal_press_lo_q[63:48];
    cal.p5      = cal_press_hi_q[15:0];
    cal.p6      = cal_press_hi_q[31:16];
    cal.p7      = cal_press_hi_q[47:32];
    cal.p8      = cal_press_hi_q[63:48];
    cal.p9      = cal_press_nine_q;
    cal.h1      = cal_hum_a_q[7:0];
    cal.h2      = cal_hum_a_q[23:8];
    cal.h3      = cal_hum_a_q[31:24];
    cal.h6      = cal_hum_a_q[39:32];
    cal.h4      = cal_hum_b_q[15:0];
    cal.h5      = cal_hum_b_q[31:16];
    cal.has_hum = has_hum_q;
  end

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[TotalLat-2:0], accept};
    end
  end

  // raw readings wait for the fine temperature
  always_ff @(posedge clk_i) begin
    rp_q[0] <= raw_press_i;
    rh_q[0] <= raw_hum_i;
    for (int i = 1; i < int'(TempLat); i++) begin
      rp_q[i] <= rp_q[i-1];
      rh_q[i] <= rh_q[i-1];
    end
  end

  esc_temp u_temp (
    .clk_i      (clk_i),
    .cal_i      (cal),
    .raw_temp_i (raw_temp_i),
    .fine_o     (fine),
    .temp_o     (temp)
  );

  esc_hum u_hum (
    .clk_i     (clk_i),
    .cal_i     (cal),
    .fine_i    (fine),
    .raw_hum_i (rh_q[TempLat-1]),
    .hum_o     (hum)
  );

  esc_press u_press (
    .clk_i       (clk_i),
    .cal_i       (cal),
    .fine_i      (fine),
    .raw_press_i (rp_q[TempLat-1]),
    .press_o     (press)
  );

  // align temperature and humidity with pressure
  always_ff @(posedge clk_i) begin
    temp_dly_q[0] <= temp;
    for (int i = 1; i < int'(PressLat); i++) begin
      temp_dly_q[i] <= temp_dly_q[i-1];
    end
    hum_dly_q[0] <= hum;
    for (int i = 1; i < int'(PressLat - HumLat); i++) begin
      hum_dly_q[i] <= hum_dly_q[i-1];
    end
  end

  assign done_o        = vld_q[TotalLat-1];
  assign temp_centi_o  = temp_dly_q[PressLat-1];
  assign press_q24_8_o = press;
  assign hum_q22_10_o  = hum_dly_q[PressLat-HumLat-1];

  a_fixed_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##TotalLat done_o)
    else $error("transfer did not complete after pipeline latency");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, TotalLat))
    else $error("result without matching input transfer");

  a_hum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (hum_q22_10_o <= 17'd102400))
    else $error("humidity outside clamp range");

endmodule

FILE: src/esc_temp.sv
// ----------------------------------------------------------------------------
// esc_temp
// Three-stage fine temperature and centi-degree temperature pipeline.
// ----------------------------------------------------------------------------
module esc_temp (
  input  logic                clk_i,
  input  esc_pkg::cal_t       cal_i,
  input  logic [19:0]         raw_temp_i,
  output logic signed [31:0]  fine_o,
  output logic signed [31:0]  temp_o
);
  import esc_pkg::*;

  logic        [31:0] ta, td;
  logic signed [31:0] a_d, a_q, a2_q, dsq_d, dsq_q, b_d, b_q, fine_d, fine_q, temp_d, temp_q;

  always_comb begin
    ta     = {15'd0, raw_temp_i[19:3]} - {15'd0, cal_i.t1, 1'b0};
    a_d    = ($signed(ta) * 32'(cal_i.t2)) >>> 11;
    td     = {16'd0, raw_temp_i[19:4]} - {16'd0, cal_i.t1};
    dsq_d  = $signed(td * td);
    b_d    = ((dsq_q >>> 12) * 32'(cal_i.t3)) >>> 14;
    fine_d = a2_q + b_q;
    temp_d = ((fine_d <<< 2) + fine_d + 32'sd128) >>> 8;
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    dsq_q  <= dsq_d;
    a2_q   <= a_q;
    b_q    <= b_d;
    fine_q <= fine_d;
    temp_q <= temp_d;
  end

  assign fine_o = fine_q;
  assign temp_o = temp_q;

endmodule

FILE: src/esc_hum.sv
// ----------------------------------------------------------------------------
// esc_hum
// Seven-stage humidity compensation pipeline with clamp and enable.
// ----------------------------------------------------------------------------
module esc_hum (
  input  logic               clk_i,
  input  esc_pkg::cal_t      cal_i,
  input  logic signed [31:0] fine_i,
  input  logic [15:0]        raw_hum_i,
  output logic [16:0]        hum_o
);
  import esc_pkg::*;

  logic signed [31:0] v, xa_d, xa_q, vh6_d, vh6_q, vh3_d, vh3_q;
  logic signed [31:0] x_q, x2_q, ya_q, y_d, y_q, vv_q, s, ss_q, vv2_q, sh_q, vv3_q, r, rc;
  logic [16:0]        hum_q;

  always_comb begin
    v     = fine_i - 32'sd76800;
    xa_d  = $signed({2'b0, raw_hum_i, 14'b0}) - (32'(cal_i.h4) <<< 20)
            - v * 32'(cal_i.h5) + 32'sd16384;
    vh6_d = (v * 32'(cal_i.h6)) >>> 10;
    vh3_d = ((v * $signed({24'd0, cal_i.h3})) >>> 11) + 32'sd32768;
    y_d   = ((((ya_q >>> 10) + 32'sd2097152) * 32'(cal_i.h2)) + 32'sd8192) >>> 14;
    s     = vv_q >>> 15;
    r     = vv3_q - (sh_q >>> 4);
    if (r < 0) begin
      rc = '0;
    end else if (r > HumClampMax) begin
      rc = HumClampMax;
    end else begin
      rc = r;
    end
  end

  always_ff @(posedge clk_i) begin
    xa_q  <= xa_d;
    vh6_q <= vh6_d;
    vh3_q <= vh3_d;
    x_q   <= xa_q >>> 15;
    ya_q  <= vh6_q * vh3_q;
    x2_q  <= x_q;
    y_q   <= y_d;
    vv_q  <= x2_q * y_q;
    ss_q  <= s * s;
    vv2_q <= vv_q;
    sh_q  <= (ss_q >>> 7) * $signed({24'd0, cal_i.h1});
    vv3_q <= vv2_q;
    hum_q <= cal_i.has_hum ? rc[28:12] : '0;
  end

  assign hum_o = hum_q;

endmodule

FILE: src/esc_div.sv
// ----------------------------------------------------------------------------
// esc_div
// Pipelined restoring divider, two quotient bits per stage, signed result.
// ----------------------------------------------------------------------------
module esc_div (
  input  logic               clk_i,
  input  logic [63:0]        num_i,
  input  logic [30:0]        den_i,
  input  logic               neg_i,
  input  logic               zero_i,
  output logic signed [63:0] quot_o,
  output logic               zero_o
);
  import esc_pkg::*;

  typedef struct packed {
    logic [31:0] rem;
    logic [63:0] num;
    logic [30:0] den;
    logic        neg;
    logic        zero;
  } div_t;

  function automatic div_t div_step(div_t s);
    div_t        o;
    logic [31:0] r;
    o = s;
    for (int k = 0; k < int'(DivBitsPerStage); k++) begin
      r = {o.rem[30:0], o.num[63]};
      o.num = {o.num[62:0], 1'b0};
      if (r >= {1'b0, o.den}) begin
        r = r - {1'b0, o.den};
        o.num[0] = 1'b1;
      end
      o.rem = r;
    end
    return o;
  endfunction

  div_t              st_q [DivStages];
  div_t              st_in [DivStages];
  logic signed [63:0] quot_q;
  logic              zero_q;

  assign st_in[0] = '{rem: '0, num: num_i, den: den_i, neg: neg_i, zero: zero_i};

  for (genvar i = 1; i < int'(DivStages); i++) begin : g_link
    assign st_in[i] = st_q[i-1];
  end

  for (genvar i = 0; i < int'(DivStages); i++) begin : g_stage
    always_ff @(posedge clk_i) begin
      st_q[i] <= div_step(st_in[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= st_q[DivStages-1].neg ? -$signed(st_q[DivStages-1].num)
                                    : $signed(st_q[DivStages-1].num);
    zero_q <= st_q[DivStages-1].zero;
  end

  assign quot_o = quot_q;
  assign zero_o = zero_q;

endmodule

FILE: src/esc_press.sv
// ----------------------------------------------------------------------------
// esc_press
// Pressure compensation: five pre-divide stages, divider, three post stages.
// ----------------------------------------------------------------------------
module esc_press (
  input  logic               clk_i,
  input  esc_pkg::cal_t      cal_i,
  input  logic signed [31:0] fine_i,
  input  logic [19:0]        raw_press_i,
  output logic [31:0]        press_o
);
  import esc_pkg::*;

  logic signed [32:0] v1;
  logic signed [65:0] v1sq_full;
  logic signed [63:0] v1sq_q, v2a_q, v1b_q, v2_q, x_q, dd_q, nn_q, d;
  logic signed [48:0] v1p5_d, v1p5_q, v1p2_d, v1p2_q, v1p5b_q, v1p2b_q;
  logic [20:0]        np_q, np2_q, np3_q;
  logic [63:0]        mn_q, dabs;
  logic [30:0]        md_q;
  logic               neg_q, zero_q;

  logic signed [63:0] q, ps, pc_q, pc2_q, w2_q, w2b_q, w1m_q, fin;
  logic               qz, z1_q, z2_q;
  logic [63:0]        lolo_q, ps2;
  logic [31:0]        hilo_q, press_q;

  always_comb begin
    v1        = 33'(fine_i) - 33'sd128000;
    v1sq_full = v1 * v1;
    v1p5_d    = v1 * cal_i.p5;
    v1p2_d    = v1 * cal_i.p2;
    d         = dd_q >>> 33;
    dabs      = d[63] ? 64'(-d) : 64'(d);
  end

  always_ff @(posedge clk_i) begin
    v1sq_q  <= v1sq_full[63:0];
    v1p5_q  <= v1p5_d;
    v1p2_q  <= v1p2_d;
    np_q    <= 21'd1048576 - {1'b0, raw_press_i};
    v2a_q   <= v1sq_q * 64'(cal_i.p6);
    v1b_q   <= v1sq_q * 64'(cal_i.p3);
    v1p5b_q <= v1p5_q;
    v1p2b_q <= v1p2_q;
    np2_q   <= np_q;
    v2_q    <= v2a_q + (64'(v1p5b_q) <<< 17) + (64'(cal_i.p4) <<< 35);
    x_q     <= (v1b_q >>> 8) + (64'(v1p2b_q) <<< 12) + (64'sd1 <<< 47);
    np3_q   <= np2_q;
    dd_q    <= x_q * $signed({48'd0, cal_i.p1});
    nn_q    <= ($signed({12'd0, np3_q, 31'd0}) - v2_q) * 64'sd3125;
    mn_q    <= nn_q[63] ? 64'(-nn_q) : 64'(nn_q);
    md_q    <= dabs[30:0];
    neg_q   <= nn_q[63] ^ d[63];
    zero_q  <= (d == 64'sd0);
  end

  esc_div u_div (
    .clk_i  (clk_i),
    .num_i  (mn_q),
    .den_i  (md_q),
    .neg_i  (neg_q),
    .zero_i (zero_q),
    .quot_o (q),
    .zero_o (qz)
  );

  always_comb begin
    ps  = q >>> 13;
    ps2 = lolo_q + {hilo_q[30:0], 33'd0};
    fin = ((pc2_q + (w1m_q >>> 25) + w2b_q) >>> 8) + (64'(cal_i.p7) <<< 4);
  end

  always_ff @(posedge clk_i) begin
    lolo_q  <= {32'd0, ps[31:0]} * {32'd0, ps[31:0]};
    hilo_q  <= ps[63:32] * ps[31:0];
    w2_q    <= (q * 64'(cal_i.p8)) >>> 19;
    pc_q    <= q;
    z1_q    <= qz;
    w1m_q   <= $signed(ps2) * 64'(cal_i.p9);
    w2b_q   <= w2_q;
    pc2_q   <= pc_q;
    z2_q    <= z1_q;
    press_q <= z2_q ? '0 : fin[31:0];
  end

  assign press_o = press_q;

endmodule
